FILE: hdl/qslerp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_pkg
// shared constants and types for the quaternion slerp pipeline
// ----------------------------------------------------------------------------
package qslerp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CW           = 34;   // cordic datapath width
  localparam int SQRT_STEPS   = 15;   // one root bit per stage
  localparam int SQW          = 30;   // sqrt remainder / root width
  localparam int QBITS        = 18;   // quotient bits of the weight divider
  localparam int NW           = 52;   // divider remainder width
  localparam int KW           = QBITS + 2;
  localparam int ROT_LANES    = 3;
  localparam int DIV_LANES    = 2;

  localparam logic [14:0] ONE_Q14      = 15'd16384;
  localparam logic [14:0] NEAR_THR_RST = 15'd16382;
  localparam logic signed [CW-1:0] ROT_X0 = 34'sd1073741824;

  // atan(2^-i) in q2.30, rounded to nearest
  localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  // item data that rides alongside the arithmetic
  typedef struct packed {
    logic [3:0][15:0] a;      // w x y z
    logic [3:0][15:0] b;      // original second quaternion
    logic [15:0]      t;
    logic             flip;   // dot was negative
    logic             pass_a; // fraction at or below zero
    logic             pass_b; // fraction at or above one
    logic             lin;    // use linear weights
    logic [14:0]      cc;     // clamped cosine
  } qslerp_sb_t;

endpackage

FILE: hdl/qslerp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_in_if
// input word channel: two quaternions and a blend fraction
// ----------------------------------------------------------------------------
interface qslerp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_w;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] b_w;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic signed [15:0] frac;

  modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, frac,
                  input ready);
  modport sink (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, frac,
                output ready);
endinterface

FILE: hdl/qslerp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_out_if
// output word channel: interpolated quaternion
// ----------------------------------------------------------------------------
interface qslerp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_w;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;

  modport source (output valid, out_w, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

FILE: hdl/qslerp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module qslerp_sqrt import qslerp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [28:0]   n_i,
  input  qslerp_sb_t    sb_i,
  output logic          vld_o,
  output logic [14:0]   s_o,
  output qslerp_sb_t    sb_o
);

  logic [SQRT_STEPS-1:0] vld_q;
  logic [SQW-1:0]        n_s [SQRT_STEPS];
  logic [SQW-1:0]        r_s [SQRT_STEPS];
  logic [SQW-1:0]        n_d [SQRT_STEPS];
  logic [SQW-1:0]        r_d [SQRT_STEPS];
  logic [SQW-1:0]        n_q [SQRT_STEPS];
  logic [SQW-1:0]        r_q [SQRT_STEPS];
  qslerp_sb_t            sb_q [SQRT_STEPS];

  always_comb begin
    logic [SQW-1:0] bit_v;
    logic [SQW-1:0] trial;
    n_s[0] = SQW'(n_i);
    r_s[0] = '0;
    for (int i = 1; i < SQRT_STEPS; i++) begin
      n_s[i] = n_q[i-1];
      r_s[i] = r_q[i-1];
    end
    for (int i = 0; i < SQRT_STEPS; i++) begin
      bit_v = SQW'(1) << (2 * (SQRT_STEPS - 1 - i));
      trial = r_s[i] + bit_v;
      if (n_s[i] >= trial) begin
        n_d[i] = n_s[i] - trial;
        r_d[i] = (r_s[i] >> 1) + bit_v;
      end else begin
        n_d[i] = n_s[i];
        r_d[i] = r_s[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQRT_STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < SQRT_STEPS; i++) begin
        n_q[i] <= n_d[i];
        r_q[i] <= r_d[i];
        sb_q[i] <= (i == 0) ? sb_i : sb_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign vld_o = vld_q[SQRT_STEPS-1];
  assign s_o   = r_q[SQRT_STEPS-1][14:0];
  assign sb_o  = sb_q[SQRT_STEPS-1];

endmodule

FILE: hdl/qslerp_cordic_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_vec
// pipelined cordic in vectoring mode, returns the angle of (x, y)
// ----------------------------------------------------------------------------
module qslerp_cordic_vec import qslerp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  qslerp_sb_t           sb_i,
  output logic                 vld_o,
  output logic signed [CW-1:0] w_o,
  output qslerp_sb_t           sb_o
);

  logic [CORDIC_STEPS-1:0] vld_q;
  logic signed [CW-1:0]    x_s [CORDIC_STEPS];
  logic signed [CW-1:0]    y_s [CORDIC_STEPS];
  logic signed [CW-1:0]    z_s [CORDIC_STEPS];
  logic signed [CW-1:0]    x_d [CORDIC_STEPS];
  logic signed [CW-1:0]    y_d [CORDIC_STEPS];
  logic signed [CW-1:0]    z_d [CORDIC_STEPS];
  logic signed [CW-1:0]    x_q [CORDIC_STEPS];
  logic signed [CW-1:0]    y_q [CORDIC_STEPS];
  logic signed [CW-1:0]    z_q [CORDIC_STEPS];
  qslerp_sb_t              sb_q [CORDIC_STEPS];

  always_comb begin
    x_s[0] = x_i;
    y_s[0] = y_i;
    z_s[0] = '0;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      x_s[i] = x_q[i-1];
      y_s[i] = y_q[i-1];
      z_s[i] = z_q[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      // drive y toward zero
      if (!y_s[i][CW-1]) begin
        x_d[i] = x_s[i] + (y_s[i] >>> i);
        y_d[i] = y_s[i] - (x_s[i] >>> i);
        z_d[i] = z_s[i] + ATAN_Q30[i];
      end else begin
        x_d[i] = x_s[i] - (y_s[i] >>> i);
        y_d[i] = y_s[i] + (x_s[i] >>> i);
        z_d[i] = z_s[i] - ATAN_Q30[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CORDIC_STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
        sb_q[i] <= (i == 0) ? sb_i : sb_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign vld_o = vld_q[CORDIC_STEPS-1];
  assign w_o   = z_q[CORDIC_STEPS-1];
  assign sb_o  = sb_q[CORDIC_STEPS-1];

endmodule

FILE: hdl/qslerp_cordic_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_rot
// pipelined cordic in rotation mode, three lanes, gain-scaled sines
// ----------------------------------------------------------------------------
module qslerp_cordic_rot import qslerp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] z_i [ROT_LANES],
  input  qslerp_sb_t           sb_i,
  output logic                 vld_o,
  output logic signed [CW-1:0] y_o [ROT_LANES],
  output qslerp_sb_t           sb_o
);

  logic [CORDIC_STEPS-1:0] vld_q;
  logic signed [CW-1:0]    x_s [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    y_s [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    z_s [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    x_d [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    y_d [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    z_d [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    x_q [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    y_q [ROT_LANES][CORDIC_STEPS];
  logic signed [CW-1:0]    z_q [ROT_LANES][CORDIC_STEPS];
  qslerp_sb_t              sb_q [CORDIC_STEPS];

  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      x_s[l][0] = ROT_X0;
      y_s[l][0] = '0;
      z_s[l][0] = z_i[l];
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        x_s[l][i] = x_q[l][i-1];
        y_s[l][i] = y_q[l][i-1];
        z_s[l][i] = z_q[l][i-1];
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        // drive residual angle toward zero
        if (!z_s[l][i][CW-1]) begin
          x_d[l][i] = x_s[l][i] - (y_s[l][i] >>> i);
          y_d[l][i] = y_s[l][i] + (x_s[l][i] >>> i);
          z_d[l][i] = z_s[l][i] - ATAN_Q30[i];
        end else begin
          x_d[l][i] = x_s[l][i] + (y_s[l][i] >>> i);
          y_d[l][i] = y_s[l][i] - (x_s[l][i] >>> i);
          z_d[l][i] = z_s[l][i] + ATAN_Q30[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CORDIC_STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < ROT_LANES; l++) begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          x_q[l][i] <= x_d[l][i];
          y_q[l][i] <= y_d[l][i];
          z_q[l][i] <= z_d[l][i];
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        sb_q[i] <= (i == 0) ? sb_i : sb_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      y_o[l] = y_q[l][CORDIC_STEPS-1];
    end
  end

  assign vld_o = vld_q[CORDIC_STEPS-1];
  assign sb_o  = sb_q[CORDIC_STEPS-1];

endmodule

FILE: hdl/qslerp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_div
// pipelined restoring divider, two lanes sharing one divisor
// k = (y * 16384) / d, truncated toward zero
// ----------------------------------------------------------------------------
module qslerp_div import qslerp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] y_i [DIV_LANES],
  input  logic signed [CW-1:0] d_i,
  input  qslerp_sb_t           sb_i,
  output logic                 vld_o,
  output logic signed [KW-1:0] k_o [DIV_LANES],
  output qslerp_sb_t           sb_o
);

  logic [QBITS:0]       vld_q;
  logic [NW-1:0]        num_q [DIV_LANES];
  logic [DIV_LANES-1:0] neg0_q;
  logic [CW-1:0]        d0_q;
  qslerp_sb_t           sb0_q;

  logic [NW-1:0]        rem_s [DIV_LANES][QBITS];
  logic [QBITS-1:0]     quo_s [DIV_LANES][QBITS];
  logic [NW-1:0]        rem_d [DIV_LANES][QBITS];
  logic [QBITS-1:0]     quo_d [DIV_LANES][QBITS];
  logic [NW-1:0]        rem_q [DIV_LANES][QBITS];
  logic [QBITS-1:0]     quo_q [DIV_LANES][QBITS];
  logic [CW-1:0]        d_s   [QBITS];
  logic [CW-1:0]        d_q   [QBITS];
  logic [DIV_LANES-1:0] neg_s [QBITS];
  logic [DIV_LANES-1:0] neg_q [QBITS];
  qslerp_sb_t           sb_q  [QBITS];

  // magnitude and scale
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        num_q[l]  <= NW'({(y_i[l][CW-1] ? CW'(-y_i[l]) : CW'(y_i[l])), 14'b0});
        neg0_q[l] <= y_i[l][CW-1];
      end
      d0_q  <= d_i;
      sb0_q <= sb_i;
    end
  end

  always_comb begin
    logic [NW-1:0] dsh;
    d_s[0]   = d0_q;
    neg_s[0] = neg0_q;
    for (int j = 1; j < QBITS; j++) begin
      d_s[j]   = d_q[j-1];
      neg_s[j] = neg_q[j-1];
    end
    for (int l = 0; l < DIV_LANES; l++) begin
      rem_s[l][0] = num_q[l];
      quo_s[l][0] = '0;
      for (int j = 1; j < QBITS; j++) begin
        rem_s[l][j] = rem_q[l][j-1];
        quo_s[l][j] = quo_q[l][j-1];
      end
      for (int j = 0; j < QBITS; j++) begin
        dsh = NW'(d_s[j]) << (QBITS - 1 - j);
        if (rem_s[l][j] >= dsh) begin
          rem_d[l][j] = rem_s[l][j] - dsh;
          quo_d[l][j] = quo_s[l][j] | (QBITS'(1) << (QBITS - 1 - j));
        end else begin
          rem_d[l][j] = rem_s[l][j];
          quo_d[l][j] = quo_s[l][j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QBITS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        for (int j = 0; j < QBITS; j++) begin
          rem_q[l][j] <= rem_d[l][j];
          quo_q[l][j] <= quo_d[l][j];
        end
      end
      for (int j = 0; j < QBITS; j++) begin
        d_q[j]   <= d_s[j];
        neg_q[j] <= neg_s[j];
        sb_q[j]  <= (j == 0) ? sb0_q : sb_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  always_comb begin
    logic signed [KW-1:0] mag;
    for (int l = 0; l < DIV_LANES; l++) begin
      mag    = $signed(KW'(quo_q[l][QBITS-1]));
      k_o[l] = neg_q[QBITS-1][l] ? -mag : mag;
    end
  end

  assign vld_o = vld_q[QBITS];
  assign sb_o  = sb_q[QBITS-1];

endmodule

FILE: hdl/quaternion_slerp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp_core
// spherical linear interpolation of two q2.14 unit quaternions
// ----------------------------------------------------------------------------
// usage
//   in_i carries one word per item: quaternions a and b and fraction frac,
//   all signed q2.14; out_o returns one word per item, the blended
//   quaternion, saturated to 16 bits; valid/ready on both channels
//   cfg_we_i/cfg_data_i write the near-threshold cosine; write it only
//   while no word is in flight
// timing
//   fully pipelined: a new word can be taken every cycle while out_o is not
//   stalled, sustained rate is one word per clock; the depth comes from the
//   sqrt (15 stages), the two cordic chains (16 stages each) and the weight
//   divider (19 stages)
// reset
//   rst_ni clears every stage valid bit and loads the threshold with 16382
// backpressure
//   when out_o holds a word that is not taken, the whole pipeline freezes
//   and in_i.ready drops in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module quaternion_slerp_core import qslerp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_data_i,
  qslerp_in_if.sink   in_i,
  qslerp_out_if.source out_o
);

  logic        en;
  logic [14:0] near_thr_q;

  // front stages
  logic                vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q;
  qslerp_sb_t          sb1_d, sb1_q, sb2_q, sb3_q, sb3_d, sb4_q, sb5_q, sb6_q;
  logic signed [31:0]  p2_q [4];
  logic [28:0]         n4_q;

  // unit boundaries
  logic                 vld_sq, vld_vc, vld_rt, vld_dv;
  logic [14:0]          s_sq;
  qslerp_sb_t           sb_sq, sb_vc_in, sb_vc, sb_rt, sb_dv_in, sb_dv;
  logic signed [CW-1:0] w_vc;
  logic signed [CW-1:0] ang5_q [ROT_LANES];
  logic signed [CW-1:0] y_rt [ROT_LANES];
  logic signed [CW-1:0] y_div [DIV_LANES];
  logic signed [KW-1:0] k_dv [DIV_LANES];

  // back stages
  logic signed [35:0]   pa6_q [4];
  logic signed [36:0]   pb6_q [4];
  logic [3:0][15:0]     out_q;

  // a stalled output freezes every stage
  assign en         = !vld7_q || out_o.ready;
  assign in_i.ready = en;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q <= NEAR_THR_RST;
    end else if (cfg_we_i) begin
      near_thr_q <= cfg_data_i;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_i.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld_vc;
      vld6_q <= vld_dv;
      vld7_q <= vld6_q;
    end
  end

  // stage 1: capture the input word
  always_comb begin
    sb1_d      = '0;
    sb1_d.a[0] = in_i.a_w;
    sb1_d.a[1] = in_i.a_x;
    sb1_d.a[2] = in_i.a_y;
    sb1_d.a[3] = in_i.a_z;
    sb1_d.b[0] = in_i.b_w;
    sb1_d.b[1] = in_i.b_x;
    sb1_d.b[2] = in_i.b_y;
    sb1_d.b[3] = in_i.b_z;
    sb1_d.t    = in_i.frac;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb1_q <= sb1_d;
    end
  end

  // stage 2: the four dot-product terms, one multiplier per lane
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p2_q[i] <= $signed(sb1_q.a[i]) * $signed(sb1_q.b[i]);
      end
      sb2_q <= sb1_q;
    end
  end

  // stage 3: dot sum, shorter-arc flip, cosine and path decision
  always_comb begin
    logic signed [33:0] dot;
    logic [33:0]        adot;
    logic [19:0]        c;
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + 34'(p2_q[i]);
    end
    adot = dot[33] ? 34'(-dot) : 34'(dot);
    c    = adot[33:14];
    sb3_d        = sb2_q;
    sb3_d.flip   = dot[33];
    sb3_d.pass_a = sb2_q.t[15] || (sb2_q.t == 16'd0);
    sb3_d.pass_b = !sb2_q.t[15] && (sb2_q.t >= 16'(ONE_Q14));
    // above the threshold the trig weights are not needed
    sb3_d.lin    = c > 20'(near_thr_q);
    sb3_d.cc     = (c > 20'(ONE_Q14)) ? ONE_Q14 : c[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb3_q <= sb3_d;
    end
  end

  // stage 4: 1 - c^2 in q1.28
  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q  <= 29'(30'd268435456 - (30'(sb3_q.cc) * 30'(sb3_q.cc)));
      sb4_q <= sb3_q;
    end
  end

  qslerp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld4_q),
    .n_i    (n4_q),
    .sb_i   (sb4_q),
    .vld_o  (vld_sq),
    .s_o    (s_sq),
    .sb_o   (sb_sq)
  );

  // zero sine falls back to linear weights
  always_comb begin
    sb_vc_in     = sb_sq;
    sb_vc_in.lin = sb_sq.lin || (s_sq == 15'd0);
  end

  qslerp_cordic_vec u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_sq),
    .x_i    ($signed({3'b000, sb_sq.cc, 16'h0000})),
    .y_i    ($signed({3'b000, s_sq, 16'h0000})),
    .sb_i   (sb_vc_in),
    .vld_o  (vld_vc),
    .w_o    (w_vc),
    .sb_o   (sb_vc)
  );

  // stage 5: partial angles (1-t)w and tw, floor-shifted back to q2.30, plus w itself
  always_ff @(posedge clk_i) begin
    logic signed [16:0] om_t;
    logic signed [50:0] prod0;
    logic signed [50:0] prod1;
    if (en) begin
      om_t  = 17'sd16384 - $signed({sb_vc.t[15], sb_vc.t});
      prod0 = 51'(om_t) * 51'(w_vc);
      prod1 = 51'($signed(sb_vc.t)) * 51'(w_vc);
      ang5_q[0] <= CW'(prod0 >>> 14);
      ang5_q[1] <= CW'(prod1 >>> 14);
      ang5_q[2] <= w_vc;
      sb5_q     <= sb_vc;
    end
  end

  qslerp_cordic_rot u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld5_q),
    .z_i    (ang5_q),
    .sb_i   (sb5_q),
    .vld_o  (vld_rt),
    .y_o    (y_rt),
    .sb_o   (sb_rt)
  );

  // a non-positive sine of w also forces linear weights
  always_comb begin
    sb_dv_in     = sb_rt;
    sb_dv_in.lin = sb_rt.lin || y_rt[2][CW-1] || (y_rt[2] == '0);
    y_div[0]     = y_rt[0];
    y_div[1]     = y_rt[1];
  end

  qslerp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_rt),
    .y_i    (y_div),
    .d_i    (y_rt[2]),
    .sb_i   (sb_dv_in),
    .vld_o  (vld_dv),
    .k_o    (k_dv),
    .sb_o   (sb_dv)
  );

  // stage 6: pick weights and form the eight weighted terms
  always_ff @(posedge clk_i) begin
    logic signed [KW-1:0] k0;
    logic signed [KW-1:0] k1;
    logic signed [16:0]   bf;
    if (en) begin
      k0 = sb_dv.lin ? KW'(17'sd16384 - $signed({sb_dv.t[15], sb_dv.t})) : k_dv[0];
      k1 = sb_dv.lin ? KW'($signed(sb_dv.t)) : k_dv[1];
      for (int i = 0; i < 4; i++) begin
        bf       = sb_dv.flip ? -17'($signed(sb_dv.b[i])) : 17'($signed(sb_dv.b[i]));
        pa6_q[i] <= 36'(k0) * 36'($signed(sb_dv.a[i]));
        pb6_q[i] <= 37'(k1) * 37'(bf);
      end
      sb6_q <= sb_dv;
    end
  end

  // stage 7: round, saturate, endpoint bypass; this is the output register
  always_ff @(posedge clk_i) begin
    logic signed [37:0] r;
    logic signed [37:0] rs;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r  = 38'(pa6_q[i]) + 38'(pb6_q[i]) + 38'sd8192;
        rs = r >>> 14;
        if (sb6_q.pass_a) begin
          out_q[i] <= sb6_q.a[i];
        end else if (sb6_q.pass_b) begin
          out_q[i] <= sb6_q.b[i];
        end else if (rs > 38'sd32767) begin
          out_q[i] <= 16'h7fff;
        end else if (rs < -38'sd32768) begin
          out_q[i] <= 16'h8000;
        end else begin
          out_q[i] <= rs[15:0];
        end
      end
    end
  end

  assign out_o.valid = vld7_q;
  assign out_o.out_w = out_q[0];
  assign out_o.out_x = out_q[1];
  assign out_o.out_y = out_q[2];
  assign out_o.out_z = out_q[3];

  // a held output word must block the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld7_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");

  // fraction at or below zero returns a unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld6_q && sb6_q.pass_a) |=> (out_q[0] == $past(sb6_q.a[0])))
    else $error("pass-through of a corrupted");

  // fraction at or above one returns the unflipped b
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld6_q && sb6_q.pass_b && !sb6_q.pass_a)
      |=> (out_q[3] == $past(sb6_q.b[3])))
    else $error("pass-through of b corrupted");

  // a stall freezes the front of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(vld3_q) && $stable(vld4_q)))
    else $error("pipeline moved during stall");

endmodule

FILE: test/qslerp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_checker
// watches both word channels, predicts each blended quaternion from the
// accepted input word and compares it with the returned word in order
// ----------------------------------------------------------------------------
module qslerp_checker import qslerp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_data_i,
  qslerp_in_if.sink   in_mon,
  qslerp_out_if.sink  out_mon,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic signed [15:0] q [4];
  } quat_t;

  logic [14:0] thr_q;
  quat_t       quat_fifo [$];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint n);
    longint r, bit_v;
    r = 0;
    bit_v = 64'd1 << 30;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  function automatic longint vec_angle(longint x, longint y);
    longint z, xo;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      xo = x;
      if (y >= 0) begin
        x = x + fshr(y, i); y = y - fshr(xo, i); z = z + longint'(ATAN_Q30[i]);
      end else begin
        x = x - fshr(y, i); y = y + fshr(xo, i); z = z - longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic longint rot_sine(longint z);
    longint x, y, xo;
    x = 64'd1 << 30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      xo = x;
      if (z >= 0) begin
        x = x - fshr(y, i); y = y + fshr(xo, i); z = z - longint'(ATAN_Q30[i]);
      end else begin
        x = x + fshr(y, i); y = y - fshr(xo, i); z = z + longint'(ATAN_Q30[i]);
      end
    end
    return y;
  endfunction

  function automatic quat_t blend_quat(longint a [4], longint b [4], longint t,
                                       logic [14:0] thr);
    quat_t  res;
    longint dot, c, k0, k1, cc, s, w, ds, r;
    if (t <= 0) begin
      for (int i = 0; i < 4; i++) res.q[i] = a[i][15:0];
    end else if (t >= 16384) begin
      for (int i = 0; i < 4; i++) res.q[i] = b[i][15:0];
    end else begin
      dot = 0;
      for (int i = 0; i < 4; i++) dot = dot + a[i] * b[i];
      // shorter arc
      if (dot < 0) begin
        dot = -dot;
        for (int i = 0; i < 4; i++) b[i] = -b[i];
      end
      c = dot >>> 14;
      k0 = 16384 - t;
      k1 = t;
      if (c <= longint'(thr)) begin
        cc = (c > 16384) ? 16384 : c;
        s = isqrt(16384 * 16384 - cc * cc);
        if (s != 0) begin
          w = vec_angle(cc * 65536, s * 65536);
          ds = rot_sine(w);
          if (ds > 0) begin
            k0 = (rot_sine(fshr((16384 - t) * w, 14)) * 16384) / ds;
            k1 = (rot_sine(fshr(t * w, 14)) * 16384) / ds;
          end
        end
      end
      for (int i = 0; i < 4; i++) begin
        r = fshr(k0 * a[i] + k1 * b[i] + 8192, 14);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        res.q[i] = r[15:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint a [4];
    longint b [4];
    quat_t  got, want;
    string  nm [4];
    int     errs;
    nm = '{"out_w", "out_x", "out_y", "out_z"};
    errs = 0;
    if (!rst_ni) begin
      thr_q <= NEAR_THR_RST;
      fail_count_o <= 0;
      pending_o <= 0;
      quat_fifo.delete();
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (in_mon.valid && in_mon.ready) begin
        a = '{in_mon.a_w, in_mon.a_x, in_mon.a_y, in_mon.a_z};
        b = '{in_mon.b_w, in_mon.b_x, in_mon.b_y, in_mon.b_z};
        quat_fifo.push_back(blend_quat(a, b, longint'(in_mon.frac), thr_q));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.q = '{out_mon.out_w, out_mon.out_x, out_mon.out_y, out_mon.out_z};
        if (quat_fifo.size() == 0) begin
          $error("unexpected output word");
          errs = errs + 1;
        end else begin
          want = quat_fifo.pop_front();
          for (int i = 0; i < 4; i++)
            if (got.q[i] !== want.q[i]) begin
              $error("%s expected %0d actual %0d", nm[i], want.q[i], got.q[i]);
              errs = errs + 1;
            end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= quat_fifo.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directed and random slerp words through quaternion_slerp_core under
// random gaps on both sides, changes the near threshold between phases and
// leaves prediction and comparison to qslerp_checker
// ----------------------------------------------------------------------------
module testbench;
  import qslerp_pkg::*;

  localparam int LATENCY   = 72;
  localparam int MAX_CYCLE = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          cycle_cnt = 0;
  int          phase_num = -1;   // current random phase, long hold-off in phase 1

  qslerp_in_if  in_ch ();
  qslerp_out_if out_ch ();

  quaternion_slerp_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  qslerp_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("quaternion_slerp_core test failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random ready, with one long hold-off in phase 1
  initial begin
    int g;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (phase_num == 1 && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      g = gap_len();
      if (g == 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // unit-ish random quaternion component, sometimes anything at all
  function automatic logic signed [15:0] rnd_comp();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [15:0] rnd_frac();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'($urandom);
    if (p == 1) return 16'($urandom_range(0, 1) ? 0 : 16384);
    return 16'($urandom_range(1, 16383));
  endfunction

  task automatic send_word(logic signed [15:0] w [9]);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z} <= {w[0], w[1], w[2], w[3]};
    {in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z} <= {w[4], w[5], w[6], w[7]};
    in_ch.frac <= w[8];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_random(int n, bool_near);
    logic signed [15:0] w [9];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 8; i++) w[i] = rnd_comp();
      if (bool_near && $urandom_range(0, 1))
        for (int i = 0; i < 4; i++) w[4 + i] = w[i] + 16'($urandom_range(0, 6)) - 16'sd3;
      w[8] = rnd_frac();
      send_word(w);
    end
  endtask

  // drain then wait out the pipeline before touching the register
  task automatic settle_and_cfg(logic [14:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic signed [15:0] w [9];
    logic [14:0] thr_set [5];
    in_ch.valid = 1'b0;
    {in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z} = '0;
    {in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    in_ch.frac = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pass-through fractions, extremes, flipped arc, equal inputs
    w = '{16384, 0, 0, 0, 0, 16384, 0, 0, 0};         send_word(w);
    w = '{16384, 0, 0, 0, 0, 16384, 0, 0, 16384};     send_word(w);
    w = '{16384, 0, 0, 0, 0, 16384, 0, 0, -32768};    send_word(w);
    w = '{16384, 0, 0, 0, 0, 16384, 0, 0, 32767};     send_word(w);
    w = '{16384, 0, 0, 0, 0, 16384, 0, 0, 8192};      send_word(w);
    w = '{16384, 0, 0, 0, -16384, 0, 0, 0, 8192};     send_word(w);
    w = '{16384, 0, 0, 0, 16384, 0, 0, 0, 4096};      send_word(w);
    w = '{11585, 11585, 0, 0, 16384, 0, 0, 0, 1};     send_word(w);
    w = '{11585, 11585, 0, 0, 16384, 0, 0, 0, 16383}; send_word(w);
    w = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 8192};
    send_word(w);
    w = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 8192};
    send_word(w);
    w = '{32767, -32768, 32767, -32768, -32768, 32767, 0, 0, 12000};
    send_word(w);
    w = '{0, 0, 0, 0, 0, 0, 0, 0, 8192};              send_word(w);
    w = '{16384, 0, 0, 0, 16383, 181, 0, 0, 8192};    send_word(w);

    thr_set = '{15'd0, 15'd16384, 15'h7FFF, 15'd12000, NEAR_THR_RST};
    for (int ph = 0; ph < 5; ph++) begin
      settle_and_cfg(thr_set[ph]);
      // phase 1 fills the pipeline against a long receiver hold-off
      phase_num = ph;
      send_random(400, ph != 2);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("quaternion_slerp_core test passed");
    end else begin
      $display("quaternion_slerp_core test failed");
    end
    $finish;
  end

endmodule
